### hw/rtl/csu_pkg.sv
// Package for the console sound unit: function codes, register offsets,
// sequencer constants and lookup tables. No dependencies.
`default_nettype none
package csu_pkg;
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;
    localparam logic [1:0] FUNC_RESET = 2'd3;

    localparam logic [4:0] OFF_TRI_LIN = 5'd8;
    localparam logic [4:0] OFF_TRI_LO = 5'd10;
    localparam logic [4:0] OFF_TRI_HI = 5'd11;
    localparam logic [4:0] OFF_NOI_ENV = 5'd12;
    localparam logic [4:0] OFF_NOI_PER = 5'd14;
    localparam logic [4:0] OFF_NOI_LEN = 5'd15;
    localparam logic [4:0] OFF_STATUS = 5'd21;
    localparam logic [4:0] OFF_FRAME = 5'd23;

    localparam logic [1:0] PREG_CTRL = 2'd0;
    localparam logic [1:0] PREG_SWEEP = 2'd1;
    localparam logic [1:0] PREG_LO = 2'd2;
    localparam logic [1:0] PREG_HI = 2'd3;

    localparam logic [14:0] SEQ_Q1 = 15'd3729;
    localparam logic [14:0] SEQ_Q2 = 15'd7457;
    localparam logic [14:0] SEQ_Q3 = 15'd11186;
    localparam logic [14:0] SEQ_END4 = 15'd14915;
    localparam logic [14:0] SEQ_END5 = 15'd18641;
    localparam logic [10:0] PERIOD_MAX = 11'h7FF;

    localparam logic [3:0] MUTE_RESET = 4'hF;
    localparam int MASK_W = 4;

    function automatic logic [7:0] len_lookup(input logic [4:0] i);
        logic [7:0] t [32];
        t = '{8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
              8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
              8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
              8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30};
        return t[i];
    endfunction

    function automatic logic [11:0] noise_lookup(input logic [3:0] i);
        logic [11:0] t [16];
        t = '{12'd4, 12'd8, 12'd16, 12'd32, 12'd64, 12'd96, 12'd128, 12'd160,
              12'd202, 12'd254, 12'd380, 12'd508, 12'd762, 12'd1016, 12'd2034,
              12'd4068};
        return t[i];
    endfunction

    function automatic logic duty_lookup(input logic [1:0] d, input logic [2:0] s);
        logic [7:0] row;
        case (d)
            2'd0: row = 8'b0000_0010;
            2'd1: row = 8'b0000_0110;
            2'd2: row = 8'b0001_1110;
            default: row = 8'b1111_1001;
        endcase
        return row[s];
    endfunction

    function automatic logic [3:0] tri_lookup(input logic [4:0] s);
        return s[4] ? s[3:0] : ~s[3:0];
    endfunction

    typedef struct packed {
        logic quarter;
        logic half;
    } frame_clk_t;
endpackage
`default_nettype wire

### hw/rtl/csu_core.sv
// Sound core state and per-item update: all channels and the frame sequencer.
// Depends on csu_pkg.
`default_nettype none
module csu_core #(
    parameter int MaskW = csu_pkg::MASK_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step_en,
    input  wire logic [1:0]       func,
    input  wire logic [4:0]       reg_offset,
    input  wire logic [7:0]       write_data,
    input  wire logic [MaskW-1:0] mute_mask,
    output logic [3:0]            pulse_one_level,
    output logic [3:0]            pulse_two_level,
    output logic [3:0]            triangle_level,
    output logic [3:0]            noise_level,
    output logic [7:0]            read_data,
    output logic                  irq
);
    logic [3:0] en_reg, en_next, hold_reg, hold_next;
    logic [7:0] len_reg [4];
    logic [7:0] len_next [4];
    logic [1:0] duty_reg [2];
    logic [1:0] duty_next [2];
    logic [10:0] sper_reg [2];
    logic [10:0] sper_next [2];
    logic [10:0] stim_reg [2];
    logic [10:0] stim_next [2];
    logic [2:0] sstep_reg [2];
    logic [2:0] sstep_next [2];
    logic [1:0] swon_reg, swon_next, swdown_reg, swdown_next, swrl_reg, swrl_next;
    logic [3:0] swp_reg [2];
    logic [3:0] swp_next [2];
    logic [2:0] swsh_reg [2];
    logic [2:0] swsh_next [2];
    logic [3:0] swdiv_reg [2];
    logic [3:0] swdiv_next [2];
    logic [15:0] tgt_reg [2];
    logic [15:0] tgt_next [2];
    logic [2:0] econst_reg, econst_next, eloop_reg, eloop_next, estart_reg, estart_next;
    logic [3:0] evol_reg [3];
    logic [3:0] evol_next [3];
    logic [3:0] ediv_reg [3];
    logic [3:0] ediv_next [3];
    logic [3:0] edec_reg [3];
    logic [3:0] edec_next [3];
    logic [6:0] trv_reg, trv_next, tlc_reg, tlc_next;
    logic trf_reg, trf_next, tctl_reg, tctl_next;
    logic [10:0] tper_reg, tper_next, ttim_reg, ttim_next;
    logic [4:0] tstep_reg, tstep_next;
    logic nmode_reg, nmode_next;
    logic [11:0] nper_reg, nper_next, ntim_reg, ntim_next;
    logic [14:0] lfsr_reg, lfsr_next;
    logic five_reg, five_next, inh_reg, inh_next, flag_reg, flag_next, par_reg, par_next;
    logic [14:0] seq_reg, seq_next;
    logic [7:0] rd_reg, rd_next;

    function automatic logic [15:0] calc_target(input logic [10:0] p, input logic [2:0] sh,
                                                input logic down, input logic first);
        logic [15:0] pw, dl;
        pw = {5'd0, p};
        dl = pw >> sh;
        if (down) return pw - dl - {15'd0, first};
        return pw + dl;
    endfunction

    always_comb begin
        csu_pkg::frame_clk_t fc;
        logic [14:0] seq_end;
        logic c;
        logic [1:0] ci;
        logic [7:0] lv;
        en_next = en_reg; hold_next = hold_reg; len_next = len_reg;
        duty_next = duty_reg; sper_next = sper_reg; stim_next = stim_reg;
        sstep_next = sstep_reg; swon_next = swon_reg; swdown_next = swdown_reg;
        swrl_next = swrl_reg; swp_next = swp_reg; swsh_next = swsh_reg;
        swdiv_next = swdiv_reg; tgt_next = tgt_reg; econst_next = econst_reg;
        eloop_next = eloop_reg; estart_next = estart_reg; evol_next = evol_reg;
        ediv_next = ediv_reg; edec_next = edec_reg; trv_next = trv_reg;
        tlc_next = tlc_reg; trf_next = trf_reg; tctl_next = tctl_reg;
        tper_next = tper_reg; ttim_next = ttim_reg; tstep_next = tstep_reg;
        nmode_next = nmode_reg; nper_next = nper_reg; ntim_next = ntim_reg;
        lfsr_next = lfsr_reg; five_next = five_reg; inh_next = inh_reg;
        flag_next = flag_reg; par_next = par_reg; seq_next = seq_reg;
        rd_next = 8'd0;
        fc = '0;
        seq_end = five_reg ? csu_pkg::SEQ_END5 : csu_pkg::SEQ_END4;
        c = reg_offset[2];
        ci = {1'b0, reg_offset[2]};
        lv = csu_pkg::len_lookup(write_data[7:3]);
        case (func)
            csu_pkg::FUNC_TICK: begin
                if (!par_reg) begin
                    fc.half = (seq_reg == csu_pkg::SEQ_Q2) || (seq_reg == seq_end);
                    fc.quarter = fc.half || (seq_reg == csu_pkg::SEQ_Q1)
                                 || (seq_reg == csu_pkg::SEQ_Q3);
                    if (seq_reg == seq_end) begin
                        if (!five_reg && !inh_reg) flag_next = 1'b1;
                        seq_next = '0;
                    end else begin
                        seq_next = seq_reg + 15'd1;
                    end
                end
                par_next = ~par_reg;
            end
            csu_pkg::FUNC_WRITE: begin
                if (!reg_offset[4] && !reg_offset[3]) begin
                    case (reg_offset[1:0])
                        csu_pkg::PREG_CTRL: begin
                            duty_next[c] = write_data[7:6];
                            hold_next[ci] = write_data[5];
                            eloop_next[ci] = write_data[5];
                            econst_next[ci] = write_data[4];
                            evol_next[ci] = write_data[3:0];
                        end
                        csu_pkg::PREG_SWEEP: begin
                            swon_next[c] = write_data[7];
                            swp_next[c] = {1'b0, write_data[6:4]};
                            swdown_next[c] = write_data[3];
                            swsh_next[c] = write_data[2:0];
                            swrl_next[c] = 1'b1;
                            tgt_next[c] = calc_target(sper_reg[c], write_data[2:0],
                                                      write_data[3], !c);
                        end
                        csu_pkg::PREG_LO: begin
                            sper_next[c] = {sper_reg[c][10:8], write_data};
                            tgt_next[c] = calc_target(sper_next[c], swsh_reg[c],
                                                      swdown_reg[c], !c);
                        end
                        default: begin
                            len_next[ci] = en_reg[ci] ? lv : 8'd0;
                            sper_next[c] = {write_data[2:0], sper_reg[c][7:0]};
                            sstep_next[c] = '0;
                            estart_next[ci] = 1'b1;
                            tgt_next[c] = calc_target(sper_next[c], swsh_reg[c],
                                                      swdown_reg[c], !c);
                        end
                    endcase
                end else begin
                    case (reg_offset)
                        csu_pkg::OFF_TRI_LIN: begin
                            hold_next[2] = write_data[7];
                            tctl_next = write_data[7];
                            trv_next = write_data[6:0];
                        end
                        csu_pkg::OFF_TRI_LO: tper_next = {tper_reg[10:8], write_data};
                        csu_pkg::OFF_TRI_HI: begin
                            len_next[2] = en_reg[2] ? lv : 8'd0;
                            tper_next = {write_data[2:0], tper_reg[7:0]};
                            trf_next = 1'b1;
                        end
                        csu_pkg::OFF_NOI_ENV: begin
                            hold_next[3] = write_data[5];
                            eloop_next[2] = write_data[5];
                            econst_next[2] = write_data[4];
                            evol_next[2] = write_data[3:0];
                        end
                        csu_pkg::OFF_NOI_PER: begin
                            nmode_next = write_data[7];
                            nper_next = csu_pkg::noise_lookup(write_data[3:0]);
                        end
                        csu_pkg::OFF_NOI_LEN: begin
                            len_next[3] = en_reg[3] ? lv : 8'd0;
                            estart_next[2] = 1'b1;
                        end
                        csu_pkg::OFF_STATUS: begin
                            en_next = write_data[3:0];
                            for (int i = 0; i < 4; i++)
                                if (!write_data[i]) len_next[i] = '0;
                        end
                        csu_pkg::OFF_FRAME: begin
                            five_next = write_data[7];
                            inh_next = write_data[6];
                            if (write_data[6]) flag_next = 1'b0;
                            seq_next = '0;
                            fc.quarter = write_data[7];
                            fc.half = write_data[7];
                        end
                        default: ;
                    endcase
                end
            end
            csu_pkg::FUNC_READ: begin
                rd_next = {1'b0, flag_reg, 2'b00, len_reg[3] != '0, len_reg[2] != '0,
                           len_reg[1] != '0, len_reg[0] != '0};
                flag_next = 1'b0;
            end
            default: begin
                inh_next = 1'b0;
                flag_next = 1'b0;
                en_next = '0;
                for (int i = 0; i < 4; i++) len_next[i] = '0;
                par_next = 1'b0;
                seq_next = '0;
                tstep_next = '0;
            end
        endcase
        // frame units work on register values written by this item
        if (fc.quarter) begin
            for (int i = 0; i < 3; i++) begin
                if (estart_next[i]) begin
                    estart_next[i] = 1'b0;
                    edec_next[i] = 4'd15;
                    ediv_next[i] = evol_next[i];
                end else if (ediv_next[i] == '0) begin
                    ediv_next[i] = evol_next[i];
                    if (edec_next[i] != '0) edec_next[i] = edec_next[i] - 4'd1;
                    else if (eloop_next[i]) edec_next[i] = 4'd15;
                end else begin
                    ediv_next[i] = ediv_next[i] - 4'd1;
                end
            end
            if (trf_next) tlc_next = trv_next;
            else if (tlc_next != '0) tlc_next = tlc_next - 7'd1;
            if (!tctl_next) trf_next = 1'b0;
        end
        if (fc.half) begin
            for (int i = 0; i < 4; i++)
                if (len_next[i] != '0 && !hold_next[i]) len_next[i] = len_next[i] - 8'd1;
            for (int i = 0; i < 2; i++) begin
                if (swdiv_next[i] == '0 && swon_next[i] && swsh_next[i] != '0
                    && sper_next[i] >= 11'd8 && tgt_next[i] <= {5'd0, csu_pkg::PERIOD_MAX}) begin
                    sper_next[i] = tgt_next[i][10:0];
                    tgt_next[i] = calc_target(tgt_next[i][10:0], swsh_next[i],
                                              swdown_next[i], i == 0);
                end
                if (swdiv_next[i] == '0 || swrl_next[i]) begin
                    swdiv_next[i] = swp_next[i];
                    swrl_next[i] = 1'b0;
                end else begin
                    swdiv_next[i] = swdiv_next[i] - 4'd1;
                end
            end
        end
        // channel timers run after the frame units of the same tick
        if (func == csu_pkg::FUNC_TICK) begin
            if (!par_reg) begin
                for (int i = 0; i < 2; i++) begin
                    if (stim_reg[i] == '0) begin
                        stim_next[i] = sper_next[i];
                        sstep_next[i] = sstep_reg[i] + 3'd1;
                    end else begin
                        stim_next[i] = stim_reg[i] - 11'd1;
                    end
                end
                if (ntim_reg == '0) begin
                    ntim_next = nper_reg;
                    lfsr_next = {lfsr_reg[0] ^ (nmode_reg ? lfsr_reg[6] : lfsr_reg[1]),
                                 lfsr_reg[14:1]};
                end else begin
                    ntim_next = ntim_reg - 12'd1;
                end
            end
            if (ttim_reg == '0) begin
                ttim_next = tper_reg;
                if (len_next[2] != '0 && tlc_next != '0) tstep_next = tstep_reg + 5'd1;
            end else begin
                ttim_next = ttim_reg - 11'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg <= '0; hold_reg <= '0; swon_reg <= '0; swdown_reg <= '0; swrl_reg <= '0;
            econst_reg <= '0; eloop_reg <= '0; estart_reg <= '0;
            for (int i = 0; i < 4; i++) len_reg[i] <= '0;
            for (int i = 0; i < 2; i++) begin
                duty_reg[i] <= '0; sper_reg[i] <= '0; stim_reg[i] <= '0; sstep_reg[i] <= '0;
                swp_reg[i] <= '0; swsh_reg[i] <= '0; swdiv_reg[i] <= '0; tgt_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                evol_reg[i] <= '0; ediv_reg[i] <= '0; edec_reg[i] <= '0;
            end
            trv_reg <= '0; tlc_reg <= '0; trf_reg <= 1'b0; tctl_reg <= 1'b0;
            tper_reg <= '0; ttim_reg <= '0; tstep_reg <= '0;
            nmode_reg <= 1'b0; nper_reg <= '0; ntim_reg <= '0; lfsr_reg <= 15'd1;
            five_reg <= 1'b0; inh_reg <= 1'b0; flag_reg <= 1'b0; par_reg <= 1'b0;
            seq_reg <= '0; rd_reg <= '0;
        end else if (step_en) begin
            en_reg <= en_next; hold_reg <= hold_next; len_reg <= len_next;
            duty_reg <= duty_next; sper_reg <= sper_next; stim_reg <= stim_next;
            sstep_reg <= sstep_next; swon_reg <= swon_next; swdown_reg <= swdown_next;
            swrl_reg <= swrl_next; swp_reg <= swp_next; swsh_reg <= swsh_next;
            swdiv_reg <= swdiv_next; tgt_reg <= tgt_next; econst_reg <= econst_next;
            eloop_reg <= eloop_next; estart_reg <= estart_next; evol_reg <= evol_next;
            ediv_reg <= ediv_next; edec_reg <= edec_next; trv_reg <= trv_next;
            tlc_reg <= tlc_next; trf_reg <= trf_next; tctl_reg <= tctl_next;
            tper_reg <= tper_next; ttim_reg <= ttim_next; tstep_reg <= tstep_next;
            nmode_reg <= nmode_next; nper_reg <= nper_next; ntim_reg <= ntim_next;
            lfsr_reg <= lfsr_next; five_reg <= five_next; inh_reg <= inh_next;
            flag_reg <= flag_next; par_reg <= par_next; seq_reg <= seq_next;
            rd_reg <= rd_next;
        end
    end

    logic [3:0] env_lv [3];
    always_comb begin
        for (int i = 0; i < 3; i++) env_lv[i] = econst_reg[i] ? evol_reg[i] : edec_reg[i];
    end

    function automatic logic pulse_on(input logic [1:0] d, input logic [2:0] s, input logic e,
                                      input logic [7:0] l, input logic [10:0] p,
                                      input logic [15:0] t);
        return csu_pkg::duty_lookup(d, s) && e && l != '0 && p >= 11'd8
               && t <= {5'd0, csu_pkg::PERIOD_MAX};
    endfunction

    assign pulse_one_level = (mute_mask[0] && pulse_on(duty_reg[0], sstep_reg[0], en_reg[0],
                              len_reg[0], sper_reg[0], tgt_reg[0])) ? env_lv[0] : 4'd0;
    assign pulse_two_level = (mute_mask[1] && pulse_on(duty_reg[1], sstep_reg[1], en_reg[1],
                              len_reg[1], sper_reg[1], tgt_reg[1])) ? env_lv[1] : 4'd0;
    assign triangle_level = (mute_mask[2] && en_reg[2] && len_reg[2] != '0
                             && tper_reg >= 11'd2 && tlc_reg != '0)
                            ? csu_pkg::tri_lookup(tstep_reg) : 4'd0;
    assign noise_level = (mute_mask[3] && en_reg[3] && len_reg[3] != '0 && !lfsr_reg[0])
                         ? env_lv[2] : 4'd0;
    assign read_data = rd_reg;
    assign irq = flag_reg;
endmodule
`default_nettype wire

### hw/rtl/console_sound_unit.sv
// Top level of the console sound unit: handshake, mute register, result register.
// Depends on csu_pkg and csu_core.
//
// Usage: each transfer on the s_ channel carries one item (func, reg_offset,
// write_data): a CPU cycle tick, a register write, a status read or a soft
// reset. Each item yields exactly one transfer on the m_ channel with the four
// channel levels after the item, the read byte and the frame interrupt flag.
// An item accepted at an edge is shown valid after that edge. Throughput is
// one item per cycle while the receiver does not stall; the core state and
// the result register are updated in the same edge, so the result register
// is the only stage. When the receiver stalls, s_ready drops while a result
// waits, unless that result is taken in the same cycle. Reset clears all
// sound state, sets the noise shift register to one and the mute mask to all
// on; a mute_we write mutes at once but unmutes on the next accepted item.
`default_nettype none
module console_sound_unit #(
    parameter int MaskW = csu_pkg::MASK_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             mute_we,
    input  wire logic [MaskW-1:0] mute_wdata,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_func,
    input  wire logic [4:0]       s_reg_offset,
    input  wire logic [7:0]       s_write_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [3:0]            m_pulse_one_level,
    output logic [3:0]            m_pulse_two_level,
    output logic [3:0]            m_triangle_level,
    output logic [3:0]            m_noise_level,
    output logic [7:0]            m_read_data,
    output logic                  m_irq
);
    logic [MaskW-1:0] mask_reg;
    logic valid_reg, valid_next, take;
    logic [3:0] lv1, lv2, lvt, lvn;

    assign s_ready = !valid_reg || m_ready;
    assign take = s_valid && s_ready;
    assign valid_next = take || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= MaskW'(csu_pkg::MUTE_RESET);
            valid_reg <= 1'b0;
        end else begin
            if (mute_we) mask_reg <= mute_wdata;
            valid_reg <= valid_next;
        end
    end

    csu_core #(.MaskW(MaskW)) u_core (
        .aclk(aclk), .aresetn(aresetn), .step_en(take),
        .func(s_func), .reg_offset(s_reg_offset), .write_data(s_write_data),
        .mute_mask(mask_reg),
        .pulse_one_level(lv1), .pulse_two_level(lv2), .triangle_level(lvt),
        .noise_level(lvn), .read_data(m_read_data), .irq(m_irq)
    );

    // levels are gated by the mask at the time of the item and by the current mask
    logic [3:0] lv1_out, lv2_out, lvt_out, lvn_out;
    logic [MaskW-1:0] imask_reg;
    always_ff @(posedge aclk) begin
        if (take) imask_reg <= mask_reg;
    end
    assign lv1_out = imask_reg[0] ? lv1 : 4'd0;
    assign lv2_out = imask_reg[1] ? lv2 : 4'd0;
    assign lvt_out = imask_reg[2] ? lvt : 4'd0;
    assign lvn_out = imask_reg[3] ? lvn : 4'd0;

    assign m_valid = valid_reg;
    assign m_pulse_one_level = lv1_out;
    assign m_pulse_two_level = lv2_out;
    assign m_triangle_level = lvt_out;
    assign m_noise_level = lvn_out;
endmodule
`default_nettype wire
